/* rtl/core/key_record_match_with_stamp_assert.svh */
// Assertion macros for the key record match block.
// Used by the top level only; relies on i_clk and i_rst_n being in scope.
`ifndef KEY_RECORD_MATCH_WITH_STAMP_ASSERT_SVH
`define KEY_RECORD_MATCH_WITH_STAMP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KRMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KRMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/krms_pkg.sv */
// Shared types and constants for the key record match block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package krms_pkg;

    // Default number of record slots.
    localparam int unsigned DEF_RECORD_SLOTS = 10;

    // Field widths.
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned DIV_W     = 16;
    localparam int unsigned RND_W     = 64;
    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned OUT_IDX_W = 4;

    // Input tdata layout, lowest bit first.
    localparam int unsigned ENTRY_LSB    = 0;
    localparam int unsigned ACT_BIT      = ENTRY_LSB + SLOT_W;
    localparam int unsigned DIV_LSB      = ACT_BIT + 1;
    localparam int unsigned RND_LSB      = DIV_LSB + DIV_W;
    localparam int unsigned STAMP_IN_LSB = RND_LSB + RND_W;
    localparam int unsigned IN_USED_W    = STAMP_IN_LSB + STAMP_W;
    localparam int unsigned IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int unsigned OUT_IDX_LSB   = 0;
    localparam int unsigned OUT_STAMP_LSB = OUT_IDX_LSB + OUT_IDX_W;
    localparam int unsigned OUT_USED_W    = OUT_STAMP_LSB + STAMP_W;
    localparam int unsigned OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    // Item kind codes carried on the input tuser.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input transfer this cycle
        logic load_we;     // write the record named by the input item
        logic scan_en;     // step the record scan
        logic hit_commit;  // take the compared record as the hit
        logic res_clear;   // result is all zeros
        logic out_load;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_lookup;   // input item is a lookup
        logic match;       // compared record matches the key
        logic scan_end;    // last record is being compared
        logic out_free;    // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

/* rtl/core/key_record_match_with_stamp.sv */
// Key record match block with access stamp: top level.
// Channels: slave stream takes load and lookup items, master stream returns
// one result per item. i_s_axis_tuser is the item kind (0 load, 1 lookup).
// A load writes one record slot (ignored when the slot is out of range) and
// returns an all-zero result. A lookup scans the records in index order and
// returns the first active record whose diversifier and random value match;
// on a hit the 32-bit access counter advances and its new value is stored as
// that record's stamp and returned.
// Timing: the scan reads one record per cycle from the record memory. One item
// is in work at a time. A new item is taken once the last result sits in the
// output register, even while that result still waits.
// Reset clears all active flags and the access counter; record contents stay
// undefined until loaded. When the receiver stalls, the result holds and the
// block stops after finishing at most one further item.
`timescale 1ns / 1ps
`default_nettype none
`include "key_record_match_with_stamp_assert.svh"

module key_record_match_with_stamp
    import krms_pkg::*;
#(
    parameter int unsigned RECORD_SLOTS = DEF_RECORD_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // Fields from bit 0: entry_index[3:0], active_flag[4], diversifier[20:5],
    // random_value[84:21], stamp_in[116:85], zero pad[119:117].
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // Fields: kind[0].
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // Fields from bit 0: hit_index[3:0], hit_stamp[35:4], zero pad[39:36].
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // Fields: hit[0].
    output logic                       o_m_axis_tuser
);

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_state w_state;

    // Sequencer.
    krms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_state   (w_state)
    );

    // Record store, scan and output register.
    krms_dp #(
        .RECORD_SLOTS (RECORD_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tuser  (i_s_axis_tuser),
        .i_s_tdata  (i_s_axis_tdata),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tuser  (o_m_axis_tuser),
        .o_m_tdata  (o_m_axis_tdata)
    );

    // An accepted item keeps the input closed on the following cycle.
    `KRMS_ASSERT_NXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input ready right after a transfer")

    // A result that is not a hit carries an all-zero payload.
    `KRMS_ASSERT_IMP(a_miss_zero, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == '0, "miss or load result with nonzero payload")

    // A waiting result is never overwritten.
    `KRMS_ASSERT_IMP(a_no_overwrite, w_cmd.out_load, !o_m_axis_tvalid || i_m_axis_tready, "output register overwritten while stalled")

    // Commits only happen while scanning.
    `KRMS_ASSERT_IMP(a_hit_in_scan, w_cmd.hit_commit, w_state == ST_SCAN, "hit committed outside the scan")

endmodule

`default_nettype wire

/* rtl/core/krms_ctrl.sv */
// Controller state machine for the key record match block.
// Depends on krms_pkg; drives the datapath through t_cmd and reads t_stat.
`timescale 1ns / 1ps
`default_nettype none

module krms_ctrl
    import krms_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_valid,
    output logic       o_s_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output t_state     o_state
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.is_lookup) begin
                        n_state = ST_SCAN;
                    end else begin
                        o_cmd.load_we   = 1'b1;
                        o_cmd.res_clear = 1'b1;
                        n_state         = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.match) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state          = ST_DONE;
                end else if (i_stat.scan_end) begin
                    o_cmd.res_clear = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

/* rtl/core/krms_dp.sv */
// Datapath for the key record match block: record memory, scan, counter, output register.
// Depends on krms_pkg; controlled by krms_ctrl through t_cmd.
`timescale 1ns / 1ps
`default_nettype none

module krms_dp
    import krms_pkg::*;
#(
    parameter int unsigned RECORD_SLOTS = DEF_RECORD_SLOTS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_s_tuser,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tvalid,
    output logic                       o_m_tuser,
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int unsigned IDX_W = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(RECORD_SLOTS + 1);
    localparam int unsigned KEY_W = DIV_W + RND_W;
    localparam int unsigned PAD_W = OUT_DATA_W - OUT_USED_W;

    // Input item fields.
    logic [SLOT_W-1:0]  w_slot;
    logic               w_act;
    logic [KEY_W-1:0]   w_key;
    logic [STAMP_W-1:0] w_stamp_in;
    logic               w_slot_ok;
    logic [IDX_W-1:0]   w_waddr;

    // Record storage.
    logic [KEY_W-1:0]        r_key_mem   [RECORD_SLOTS];
    logic [STAMP_W-1:0]      r_stamp_mem [RECORD_SLOTS];
    logic [RECORD_SLOTS-1:0] r_active;

    // Scan state.
    logic [KEY_W-1:0]   r_key;
    logic [CNT_W-1:0]   r_rd_cnt;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_cmp_vld;
    logic [KEY_W-1:0]   r_rd_key;
    logic               w_rd_live;
    logic               w_match;

    // Access counter and result.
    logic [STAMP_W-1:0]   r_access_cnt;
    logic [STAMP_W-1:0]   w_cnt_inc;
    logic                 r_res_hit;
    logic [OUT_IDX_W-1:0] r_res_idx;
    logic [STAMP_W-1:0]   r_res_stamp;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic [STAMP_W-1:0]   r_out_stamp;

    // Unpack the input transfer.
    assign w_slot     = i_s_tdata[ENTRY_LSB +: SLOT_W];
    assign w_act      = i_s_tdata[ACT_BIT];
    assign w_key      = {i_s_tdata[DIV_LSB +: DIV_W], i_s_tdata[RND_LSB +: RND_W]};
    assign w_stamp_in = i_s_tdata[STAMP_IN_LSB +: STAMP_W];
    assign w_slot_ok  = (32'(w_slot) < 32'(RECORD_SLOTS));
    assign w_waddr    = IDX_W'(w_slot);

    assign w_rd_live = (r_rd_cnt < CNT_W'(RECORD_SLOTS));
    assign w_cnt_inc = r_access_cnt + STAMP_W'(1);

    // A record matches when it is active and both key parts are equal.
    assign w_match = r_cmp_vld && r_active[r_cmp_idx] && (r_rd_key == r_key);

    always_comb begin
        o_stat           = '0;
        o_stat.is_lookup = (i_s_tuser == KIND_LOOKUP);
        o_stat.match     = w_match;
        o_stat.scan_end  = r_cmp_vld && (r_cmp_idx == IDX_W'(RECORD_SLOTS - 1));
        o_stat.out_free  = !r_out_valid || i_m_tready;
    end

    // Record memory writes: loads fill a whole record, hits update the stamp.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && w_slot_ok) begin
            r_key_mem[w_waddr]   <= w_key;
            r_stamp_mem[w_waddr] <= w_stamp_in;
        end
        if (i_cmd.hit_commit) begin
            r_stamp_mem[r_cmp_idx] <= w_cnt_inc;
        end
    end

    // Registered read of the record being scanned.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en && w_rd_live) begin
            r_rd_key  <= r_key_mem[r_rd_cnt[IDX_W-1:0]];
            r_cmp_idx <= r_rd_cnt[IDX_W-1:0];
        end
    end

    // Lookup key capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= w_key;
        end
    end

    // Active flags, scan counter and access counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_rd_cnt     <= '0;
            r_cmp_vld    <= 1'b0;
            r_access_cnt <= '0;
        end else begin
            if (i_cmd.load_we && w_slot_ok) begin
                r_active[w_waddr] <= w_act;
            end
            if (i_cmd.accept) begin
                r_rd_cnt <= '0;
            end else if (i_cmd.scan_en && w_rd_live) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            r_cmp_vld <= i_cmd.scan_en && w_rd_live;
            if (i_cmd.hit_commit) begin
                r_access_cnt <= w_cnt_inc;
            end
        end
    end

    // Result of the current item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_commit) begin
            r_res_hit   <= 1'b1;
            r_res_idx   <= OUT_IDX_W'(r_cmp_idx);
            r_res_stamp <= w_cnt_inc;
        end else if (i_cmd.res_clear) begin
            r_res_hit   <= 1'b0;
            r_res_idx   <= '0;
            r_res_stamp <= '0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_hit   <= r_res_hit;
            r_out_idx   <= r_res_idx;
            r_out_stamp <= r_res_stamp;
        end
    end

    // Output valid: set on load, cleared by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_hit;
    assign o_m_tdata  = {PAD_W'(0), r_out_stamp, r_out_idx};

endmodule

`default_nettype wire
